// ----- sv/hpws_pkg.sv -----
// ----------------------------------------------------------------------------
// hpws_pkg: shared types and constants
// Opcodes, register indexes, field widths and the controller/datapath
// command and status bundles of the heading PI wheel speed block.
// ----------------------------------------------------------------------------
package hpws_pkg;

  localparam int WINDOW_DEF = 10;

  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 15;
  localparam int SPD_W   = 12;
  localparam int TICK_W  = 16;
  localparam int ERR_W   = 17;
  localparam int MAG_W   = 13;
  localparam int OUT_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int ERR_LIMIT = 26214;
  localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(4096);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

  typedef struct packed {
    logic ld_in;
    logic ld_err;
    logic do_start;
    logic do_idle;
    logic do_finish;
    logic mul_p;
    logic mul_i;
    logic acc;
    logic mag;
    logic boost;
    logic final_res;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic running;
    logic err_small;
    logic boost_need;
    logic slot_free;
  } status_t;

endpackage

// ----- sv/hpws_ctrl.sv -----
// ----------------------------------------------------------------------------
// hpws_ctrl: sequencing state machine
// Accepts one request at a time and steps the datapath through error and
// decision, then multiply, accumulate, magnitude, boost, final and result load.
// ----------------------------------------------------------------------------
module hpws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpws_pkg::status_t  stat,
  output hpws_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_MULP   = 4'd3;
  localparam logic [3:0] S_MULI   = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_MAG    = 4'd6;
  localparam logic [3:0] S_BOOST  = 4'd7;
  localparam logic [3:0] S_FINAL  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat.opcode == hpws_pkg::OP_START) begin
          cmd.do_start = 1'b1;
          state_next = S_OUT;
        end else if (!stat.running) begin
          cmd.do_idle = 1'b1;
          state_next = S_OUT;
        end else if (stat.err_small) begin
          cmd.do_finish = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_MULP;
        end
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_next = S_MULI;
      end
      S_MULI: begin
        cmd.mul_i = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag = 1'b1;
        state_next = S_BOOST;
      end
      S_BOOST: begin
        if (stat.boost_need) begin
          cmd.boost = 1'b1;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_res = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.slot_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/hpws_dp.sv -----
// ----------------------------------------------------------------------------
// hpws_dp: controller datapath
// Configuration registers, heading error, shared gain multiplier, error
// window with running sum, speed boost and clamp, tick counter and the
// output register.
// ----------------------------------------------------------------------------
module hpws_dp #(
  parameter int WINDOW = hpws_pkg::WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [hpws_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hpws_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  opcode,
  input  logic [hpws_pkg::ANGLE_W-1:0]          heading,
  input  logic                                  out_ready,
  input  hpws_pkg::cmd_t                        cmd,
  output hpws_pkg::status_t                     stat,
  output logic                                  out_valid,
  output logic signed [hpws_pkg::OUT_W-1:0]     left_speed,
  output logic signed [hpws_pkg::OUT_W-1:0]     right_speed,
  output logic                                  done_res,
  output logic                                  timed_out,
  output logic                                  active
);

  localparam int ERR_W  = hpws_pkg::ERR_W;
  localparam int MAG_W  = hpws_pkg::MAG_W;
  localparam int GAIN_W = hpws_pkg::GAIN_W;
  localparam int SUM_W  = $clog2(WINDOW * hpws_pkg::ERR_LIMIT + 1) + 1;
  localparam int MB_W   = (SUM_W > ERR_W) ? SUM_W : ERR_W;
  localparam int PROD_W = MB_W + GAIN_W + 1;
  localparam int X_W    = PROD_W + 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // configuration
  logic [hpws_pkg::ANGLE_W-1:0] target_angle;
  logic [GAIN_W-1:0]            prop_gain;
  logic [GAIN_W-1:0]            integral_gain;
  logic [hpws_pkg::THR_W-1:0]   stop_threshold;
  logic [hpws_pkg::SPD_W-1:0]   min_speed;
  logic [hpws_pkg::SPD_W-1:0]   max_speed;
  logic [hpws_pkg::TICK_W-1:0]  timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle   <= '0;
      prop_gain      <= GAIN_W'(256);
      integral_gain  <= '0;
      stop_threshold <= hpws_pkg::THR_W'(64);
      min_speed      <= hpws_pkg::SPD_W'(8);
      max_speed      <= hpws_pkg::SPD_W'(1000);
      timeout_ticks  <= hpws_pkg::TICK_W'(32000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpws_pkg::REG_TARGET:  target_angle   <= cfg_data;
        hpws_pkg::REG_KP:      prop_gain      <= cfg_data;
        hpws_pkg::REG_KI:      integral_gain  <= cfg_data;
        hpws_pkg::REG_THR:     stop_threshold <= cfg_data[hpws_pkg::THR_W-1:0];
        hpws_pkg::REG_MIN:     min_speed      <= cfg_data[hpws_pkg::SPD_W-1:0];
        hpws_pkg::REG_MAX:     max_speed      <= cfg_data[hpws_pkg::SPD_W-1:0];
        hpws_pkg::REG_TIMEOUT: timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and heading error
  logic                         opcode_r;
  logic [hpws_pkg::ANGLE_W-1:0] heading_r;
  logic signed [ERR_W-1:0]      err_r;
  logic                         small_r;

  logic [hpws_pkg::ANGLE_W-1:0] diff;
  logic signed [ERR_W-1:0]      e_raw;
  logic [ERR_W-1:0]             e_abs;
  logic                         e_over;
  logic signed [ERR_W-1:0]      e_clamp;
  logic [ERR_W-1:0]             abs_clamp;

  always_comb begin
    diff      = target_angle - heading_r;
    e_raw     = ERR_W'(signed'(diff));
    e_abs     = e_raw[ERR_W-1] ? ERR_W'(-e_raw) : ERR_W'(e_raw);
    e_over    = e_abs > ERR_W'(hpws_pkg::ERR_LIMIT);
    e_clamp   = e_over ? ERR_W'(hpws_pkg::ERR_LIMIT) : e_raw;
    abs_clamp = e_over ? ERR_W'(hpws_pkg::ERR_LIMIT) : e_abs;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      opcode_r  <= opcode;
      heading_r <= heading;
    end
    if (cmd.ld_err) begin
      err_r   <= e_clamp;
      small_r <= abs_clamp < ERR_W'(stop_threshold);
    end
  end

  // error window
  logic signed [ERR_W-1:0] win [WINDOW];
  logic [WINDOW-1:0]       win_valid;
  logic [POS_W-1:0]        pos;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [ERR_W-1:0] old_err;

  assign old_err = win_valid[pos] ? win[pos] : '0;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      win[pos] <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid  <= '0;
      window_sum <= '0;
      pos        <= '0;
    end else if (cmd.do_start) begin
      win_valid  <= '0;
      window_sum <= '0;
      pos        <= '0;
    end else if (cmd.acc) begin
      win_valid[pos] <= 1'b1;
      window_sum <= window_sum - SUM_W'(old_err) + SUM_W'(err_r);
      pos <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);
    end
  end

  // shared gain multiplier
  logic signed [GAIN_W:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [X_W-1:0]    x_r;

  always_comb begin
    mul_a = signed'({1'b0, cmd.mul_i ? integral_gain : prop_gain});
    mul_b = cmd.mul_i ? MB_W'(window_sum) : MB_W'(err_r);
    mul_p = mul_a * mul_b;
  end

  // magnitude, boost and clamp
  logic [X_W-1:0]   x_abs;
  logic [X_W-1:0]   x_sh;
  logic [MAG_W-1:0] mag;
  logic             neg;
  logic [MAG_W:0]   b3;
  logic [MAG_W-1:0] m_cl;

  always_comb begin
    x_abs = x_r[X_W-1] ? X_W'(-x_r) : X_W'(x_r);
    x_sh  = x_abs >> 8;
    b3    = {1'b0, mag} + {mag, 1'b0} + (MAG_W+1)'(1);
    m_cl  = (mag > MAG_W'(max_speed)) ? MAG_W'(max_speed) : mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_p) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_i) begin
      acc_r  <= prod_r;
      prod_r <= mul_p;
    end
    if (cmd.acc) begin
      x_r <= X_W'(acc_r) + X_W'(prod_r);
    end
    if (cmd.mag) begin
      neg <= x_r[X_W-1];
      mag <= (x_sh > X_W'(hpws_pkg::MAG_SAT - MAG_W'(1))) ? hpws_pkg::MAG_SAT
                                                         : x_sh[MAG_W-1:0];
    end else if (cmd.boost) begin
      mag <= b3[MAG_W:1];
    end
  end

  // movement state and pending result
  logic                        running;
  logic [hpws_pkg::TICK_W-1:0] tick_count;
  logic [hpws_pkg::TICK_W-1:0] tick_next;
  logic                        tmo;
  logic signed [hpws_pkg::OUT_W-1:0] res_speed;
  logic                        res_done;
  logic                        res_tmo;
  logic                        res_act;

  always_comb begin
    tick_next = (tick_count == '1) ? tick_count : tick_count + hpws_pkg::TICK_W'(1);
    tmo       = tick_next > timeout_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      tick_count <= '0;
    end else if (cmd.do_start) begin
      running    <= 1'b1;
      tick_count <= '0;
    end else if (cmd.do_finish) begin
      running <= 1'b0;
    end else if (cmd.final_res) begin
      tick_count <= tick_next;
      running    <= !tmo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_start) begin
      res_speed <= '0;
      res_done  <= 1'b0;
      res_tmo   <= 1'b0;
      res_act   <= 1'b1;
    end else if (cmd.do_idle) begin
      res_speed <= '0;
      res_done  <= 1'b0;
      res_tmo   <= 1'b0;
      res_act   <= 1'b0;
    end else if (cmd.do_finish) begin
      res_speed <= '0;
      res_done  <= 1'b1;
      res_tmo   <= 1'b0;
      res_act   <= 1'b0;
    end else if (cmd.final_res) begin
      res_speed <= neg ? -signed'(m_cl) : signed'(m_cl);
      res_done  <= 1'b0;
      res_tmo   <= tmo;
      res_act   <= !tmo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      right_speed <= res_speed;
      left_speed  <= -res_speed;
      done_res    <= res_done;
      timed_out   <= res_tmo;
      active      <= res_act;
    end
  end

  always_comb begin
    stat.opcode     = opcode_r;
    stat.running    = running;
    stat.err_small  = small_r;
    stat.boost_need = (mag != '0) && (mag < MAG_W'(min_speed));
    stat.slot_free  = !out_valid || out_ready;
  end

endmodule

// ----- sv/heading_pi_wheel_speed_top.sv -----
// ----------------------------------------------------------------------------
// heading_pi_wheel_speed_top: in-place rotation PI controller
// Heading error with half-turn wrap, PI drive over a sliding error window,
// min-speed boost and max-speed clamp, opposite wheel speed commands.
//
//   channel  signals                               direction
//   in       in_valid/in_ready, opcode, heading    request in
//   out      out_valid/out_ready, speeds, flags    result out
//   cfg      cfg_we, cfg_index, cfg_data           register write
//
// Start, idle and finishing ticks pass error, decision and output load; a
// driving tick adds multiply, accumulate, magnitude, boost while needed
// and final result. One request is worked at a time; the output register
// lets the next request enter while a result waits. A stalled output holds
// the finished result in the datapath. rst is synchronous and clears all
// control state and loads the register defaults.
// ----------------------------------------------------------------------------
module heading_pi_wheel_speed_top #(
  parameter int WINDOW = hpws_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hpws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpws_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic [hpws_pkg::ANGLE_W-1:0]       heading,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hpws_pkg::OUT_W-1:0]  left_speed,
  output logic signed [hpws_pkg::OUT_W-1:0]  right_speed,
  output logic                               done_res,
  output logic                               timed_out,
  output logic                               active
);

  hpws_pkg::cmd_t    cmd;
  hpws_pkg::status_t stat;

  hpws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpws_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .heading     (heading),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .done_res    (done_res),
    .timed_out   (timed_out),
    .active      (active)
  );

endmodule

// ----- tb/tb_heading_pi_wheel_speed_top.sv -----
// ----------------------------------------------------------------------------
// tb_heading_pi_wheel_speed_top: self-checking bench for the rotation controller
// A directed script covers idle ticks, starts, restarts, finish, error wrap and
// forcing, zero drive, boost, clamp below min and timeout. Random phases then
// rewrite all registers and send start/tick runs that close in on the target,
// mixed with noise. Results are checked against a cycle-free controller model
// in the bench, or typed script values, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_heading_pi_wheel_speed_top;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQS = 1050;
  localparam int PHASE_REQS  = 90;
  localparam int SETTLE      = 50;

  typedef struct packed {
    logic signed [hpws_pkg::OUT_W-1:0] left_spd;
    logic signed [hpws_pkg::OUT_W-1:0] right_spd;
    logic                              done;
    logic                              tmo;
    logic                              act;
  } wheel_cmd_t;

  typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic                              op;
    logic [hpws_pkg::ANGLE_W-1:0]      hdg;
    logic                              typed;
    wheel_cmd_t                        want;
    logic [hpws_pkg::CFG_IDX_W-1:0]    idx;
    logic [hpws_pkg::CFG_DAT_W-1:0]    val;
  } script_row_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_we;
  logic [hpws_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [hpws_pkg::CFG_DAT_W-1:0]      cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic                                opcode;
  logic [hpws_pkg::ANGLE_W-1:0]        heading;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [hpws_pkg::OUT_W-1:0]   left_speed;
  logic signed [hpws_pkg::OUT_W-1:0]   right_speed;
  logic                                done_res;
  logic                                timed_out;
  logic                                active;

  // controller model state and registers
  logic                                run_flag;
  int                                  win_errs[hpws_pkg::WINDOW_DEF];
  int                                  win_sum;
  int                                  win_pos;
  logic [hpws_pkg::TICK_W-1:0]         tick_cnt;
  logic [hpws_pkg::ANGLE_W-1:0]        tgt_angle;
  logic [hpws_pkg::GAIN_W-1:0]         kp_gain;
  logic [hpws_pkg::GAIN_W-1:0]         ki_gain;
  logic [hpws_pkg::THR_W-1:0]          stop_thr;
  logic [hpws_pkg::SPD_W-1:0]          min_spd;
  logic [hpws_pkg::SPD_W-1:0]          max_spd;
  logic [hpws_pkg::TICK_W-1:0]         tick_limit;

  wheel_cmd_t                          pending_cmds[$];
  script_row_t                         plan[$];
  int                                  mismatches;
  int                                  random_reqs;
  int                                  stall_cycles;
  logic                                no_idle;
  logic                                hold_req;

  heading_pi_wheel_speed_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .heading(heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_speed(left_speed), .right_speed(right_speed),
    .done_res(done_res), .timed_out(timed_out), .active(active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_window();
    for (int i = 0; i < hpws_pkg::WINDOW_DEF; i++) win_errs[i] = 0;
    win_sum = 0;
    win_pos = 0;
  endfunction

  function automatic void set_reg(input logic [hpws_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [hpws_pkg::CFG_DAT_W-1:0] val);
    case (idx)
      hpws_pkg::REG_TARGET:  tgt_angle = val;
      hpws_pkg::REG_KP:      kp_gain = val;
      hpws_pkg::REG_KI:      ki_gain = val;
      hpws_pkg::REG_THR:     stop_thr = val[hpws_pkg::THR_W-1:0];
      hpws_pkg::REG_MIN:     min_spd = val[hpws_pkg::SPD_W-1:0];
      hpws_pkg::REG_MAX:     max_spd = val[hpws_pkg::SPD_W-1:0];
      hpws_pkg::REG_TIMEOUT: tick_limit = val;
      default: ;
    endcase
  endfunction

  function automatic wheel_cmd_t rotate_step(input logic op,
                                             input logic [hpws_pkg::ANGLE_W-1:0] hdg);
    wheel_cmd_t r;
    logic [hpws_pkg::ANGLE_W-1:0] diff;
    int err;
    int err_mag;
    longint drive;
    longint mag;
    logic neg;
    r = '0;
    if (op == hpws_pkg::OP_START) begin
      clear_window();
      tick_cnt = '0;
      run_flag = 1'b1;
      r.act = 1'b1;
      return r;
    end
    if (!run_flag) return r;
    diff = tgt_angle - hdg;
    err = int'($signed(diff));
    err_mag = (err < 0) ? -err : err;
    if (err_mag > hpws_pkg::ERR_LIMIT) begin
      err = hpws_pkg::ERR_LIMIT;
      err_mag = hpws_pkg::ERR_LIMIT;
    end
    if (err_mag < int'(stop_thr)) begin
      run_flag = 1'b0;
      r.done = 1'b1;
      return r;
    end
    drive = longint'(kp_gain) * err + longint'(ki_gain) * win_sum;
    neg = drive < 0;
    mag = (neg ? -drive : drive) >> 8;
    win_sum -= win_errs[win_pos];
    win_errs[win_pos] = err;
    win_sum += err;
    win_pos = (win_pos + 1 >= hpws_pkg::WINDOW_DEF) ? 0 : win_pos + 1;
    while (mag > 0 && mag < longint'(min_spd)) mag = (3 * mag + 1) >> 1;
    if (mag > longint'(max_spd)) mag = longint'(max_spd);
    r.right_spd = neg ? -hpws_pkg::OUT_W'(mag) : hpws_pkg::OUT_W'(mag);
    r.left_spd = -r.right_spd;
    if (tick_cnt != '1) tick_cnt++;
    r.tmo = tick_cnt > tick_limit;
    if (r.tmo) run_flag = 1'b0;
    r.act = run_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  task automatic send_req(input logic op, input logic [hpws_pkg::ANGLE_W-1:0] hdg,
                          input logic typed, input wheel_cmd_t want);
    wheel_cmd_t pred;
    int gap;
    in_valid = 1'b1;
    opcode = op;
    heading = hdg;
    do @(posedge clk); while (!in_ready);
    pred = rotate_step(op, hdg);
    pending_cmds.insert(pending_cmds.size(), typed ? want : pred);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [hpws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpws_pkg::CFG_DAT_W-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    set_reg(idx, val);
  endtask

  task automatic add_req(input logic op, input logic [hpws_pkg::ANGLE_W-1:0] hdg);
    script_row_t row;
    row = '{ROW_REQ, op, hdg, 1'b0, '0, '0, '0};
    plan.insert(plan.size(), row);
  endtask

  task automatic add_typed(input logic op, input logic [hpws_pkg::ANGLE_W-1:0] hdg,
                           input wheel_cmd_t want);
    script_row_t row;
    row = '{ROW_REQ, op, hdg, 1'b1, want, '0, '0};
    plan.insert(plan.size(), row);
  endtask

  task automatic add_write(input logic [hpws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpws_pkg::CFG_DAT_W-1:0] val);
    script_row_t row;
    row = '{ROW_WRITE, hpws_pkg::OP_START, '0, 1'b0, '0, idx, val};
    plan.insert(plan.size(), row);
  endtask

  task automatic pick_config();
    write_reg(hpws_pkg::REG_TARGET, 16'($urandom));
    case ($urandom_range(0, 4))
      0: write_reg(hpws_pkg::REG_KP, 16'd0);
      1: write_reg(hpws_pkg::REG_KP, 16'hFFFF);
      default: write_reg(hpws_pkg::REG_KP, 16'($urandom_range(1, 2048)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(hpws_pkg::REG_KI, 16'd0);
      1: write_reg(hpws_pkg::REG_KI, 16'hFFFF);
      default: write_reg(hpws_pkg::REG_KI, 16'($urandom_range(0, 256)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(hpws_pkg::REG_THR, 16'd0);
      1: write_reg(hpws_pkg::REG_THR, 16'd32767);
      default: write_reg(hpws_pkg::REG_THR, 16'($urandom_range(1, 600)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(hpws_pkg::REG_MIN, 16'd0);
      1: write_reg(hpws_pkg::REG_MIN, 16'd4095);
      default: write_reg(hpws_pkg::REG_MIN, 16'($urandom_range(1, 200)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(hpws_pkg::REG_MAX, 16'd0);
      1: write_reg(hpws_pkg::REG_MAX, 16'd4095);
      default: write_reg(hpws_pkg::REG_MAX, 16'($urandom_range(50, 4095)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(hpws_pkg::REG_TIMEOUT, 16'd0);
      1: write_reg(hpws_pkg::REG_TIMEOUT, 16'hFFFF);
      default: write_reg(hpws_pkg::REG_TIMEOUT, 16'($urandom_range(3, 60)));
    endcase
  endtask

  task automatic run_sequence();
    int n;
    int span;
    int err;
    logic [hpws_pkg::ANGLE_W-1:0] hdg;
    if ($urandom_range(0, 99) < 10) begin
      send_req(1'($urandom_range(0, 1)), 16'($urandom), 1'b0, '0);
      random_reqs++;
      return;
    end
    send_req(hpws_pkg::OP_START, 16'($urandom), 1'b0, '0);
    random_reqs++;
    n = $urandom_range(1, 30);
    span = $urandom_range(0, 32767);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        hdg = 16'($urandom);
      end else begin
        err = $urandom_range(0, span);
        if ($urandom_range(0, 1)) err = -err;
        hdg = 16'(int'(tgt_angle) - err);
      end
      send_req(hpws_pkg::OP_TICK, hdg, 1'b0, '0);
      random_reqs++;
      span = span * 3 / 4;
    end
  endtask

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: left %0d right %0d done %0b tmo %0b act %0b",
                                left_speed, right_speed, done_res, timed_out, active));
      end else begin
        want = pending_cmds.pop_front();
        if (left_speed !== want.left_spd || right_speed !== want.right_spd ||
            done_res !== want.done || timed_out !== want.tmo || active !== want.act) begin
          flag_mismatch($sformatf({"mismatch exp/act: left %0d/%0d right %0d/%0d ",
                                   "done %0b/%0b tmo %0b/%0b act %0b/%0b"},
                                  want.left_spd, left_speed, want.right_spd, right_speed,
                                  want.done, done_res, want.tmo, timed_out,
                                  want.act, active));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    int phase;
    int phase_end;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = hpws_pkg::OP_START;
    heading = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    random_reqs = 0;
    stall_cycles = 0;
    run_flag = 1'b0;
    clear_window();
    tick_cnt = '0;
    tgt_angle = 16'd0;
    kp_gain = 16'd256;
    ki_gain = 16'd0;
    stop_thr = 15'd64;
    min_spd = 12'd8;
    max_spd = 12'd1000;
    tick_limit = 16'd32000;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    add_typed(hpws_pkg::OP_TICK, 16'h0000, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b0});
    add_typed(hpws_pkg::OP_TICK, 16'hFFFF, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b0});
    add_typed(hpws_pkg::OP_START, 16'h0000, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_typed(hpws_pkg::OP_TICK, 16'h0000, '{13'sd0, 13'sd0, 1'b1, 1'b0, 1'b0});
    add_typed(hpws_pkg::OP_START, 16'hFFFF, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_typed(hpws_pkg::OP_START, 16'h1234, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_req(hpws_pkg::OP_TICK, 16'h8000);
    add_req(hpws_pkg::OP_TICK, 16'h7FFF);
    add_req(hpws_pkg::OP_TICK, 16'h999A);
    add_req(hpws_pkg::OP_TICK, 16'h9999);
    add_req(hpws_pkg::OP_TICK, 16'h0040);
    add_typed(hpws_pkg::OP_TICK, 16'h003F, '{13'sd0, 13'sd0, 1'b1, 1'b0, 1'b0});
    add_write(hpws_pkg::REG_KP, 16'd0);
    add_typed(hpws_pkg::OP_START, 16'h0000, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_req(hpws_pkg::OP_TICK, 16'h1000);
    add_write(hpws_pkg::REG_KP, 16'd1);
    add_write(hpws_pkg::REG_MIN, 16'd4095);
    add_write(hpws_pkg::REG_MAX, 16'd4095);
    add_req(hpws_pkg::OP_TICK, 16'hF000);
    add_write(hpws_pkg::REG_MAX, 16'd0);
    add_req(hpws_pkg::OP_TICK, 16'hF000);
    add_write(hpws_pkg::REG_TIMEOUT, 16'd0);
    add_write(hpws_pkg::REG_THR, 16'd0);
    add_write(hpws_pkg::REG_TARGET, 16'hFFFF);
    add_write(hpws_pkg::REG_KI, 16'hFFFF);
    add_write(hpws_pkg::REG_KP, 16'hFFFF);
    add_write(hpws_pkg::REG_MAX, 16'd4095);
    add_write(hpws_pkg::REG_MIN, 16'd0);
    add_typed(hpws_pkg::OP_START, 16'h5555, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_req(hpws_pkg::OP_TICK, 16'h0000);
    add_typed(hpws_pkg::OP_TICK, 16'hAAAA, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b0});
    add_write(hpws_pkg::REG_TIMEOUT, 16'hFFFF);
    add_typed(hpws_pkg::OP_START, 16'h0000, '{13'sd0, 13'sd0, 1'b0, 1'b0, 1'b1});
    add_req(hpws_pkg::OP_TICK, 16'h7FFF);
    add_req(hpws_pkg::OP_TICK, 16'h8000);
    add_req(hpws_pkg::OP_TICK, 16'hC000);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else send_req(plan[i].op, plan[i].hdg, plan[i].typed, plan[i].want);
    end

    phase = 0;
    while (random_reqs < RANDOM_REQS) begin
      pick_config();
      no_idle = (phase % 5 == 3);
      if (phase == 2 || phase == 7) hold_req = 1'b1;
      phase_end = random_reqs + PHASE_REQS;
      while (random_reqs < phase_end) run_sequence();
      phase++;
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hpws_pkg.sv
sv/hpws_ctrl.sv
sv/hpws_dp.sv
sv/heading_pi_wheel_speed_top.sv
tb/tb_heading_pi_wheel_speed_top.sv
